@@ rtl/jbuf_pkg.sv @@
// Package with the shared types and constants of the audio playback jitter buffer.
`default_nettype none

package jbuf_pkg;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned FILL_W = 15;

  localparam logic [THR_W-1:0] THR_RESET = 15'd9600;

  typedef enum logic {
    MODE_BUFFERING,
    MODE_PLAYING
  } mode_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic load;
    logic buffering;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic at_prefill;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/audio_playback_jitter_buffer_top.sv @@
// Top level of the audio playback jitter buffer.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+------------------------------------------------
//   in      | in_valid_i / in_ready_o | req_type_i, sample_in_i, period_start_i
//   out     | out_valid_o/out_ready_i | sample_out_o, from_store_o, is_buffering_o,
//           |                         | fill_level_o
//   cfg     | cfg_we_i                | cfg_wdata_i (prefill threshold)
//
// A read beat's result appears in the cycle after the beat is accepted.
// The output register holds one result, so input beats stall only while it is full and
// not being taken; the memory has a single registered read port.
// Reset empties the store, enters buffering mode and sets the threshold to 9600.
// Writes to a full store are dropped and produce no output beat.
`default_nettype none

module audio_playback_jitter_buffer_top #(
  parameter int unsigned STORE_DEPTH = 16384
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic        [jbuf_pkg::THR_W-1:0] cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              req_type_i,
  input  wire logic signed [jbuf_pkg::SMP_W-1:0] sample_in_i,
  input  wire logic                              period_start_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed      [jbuf_pkg::SMP_W-1:0] sample_out_o,
  output logic                                   from_store_o,
  output logic                                   is_buffering_o,
  output logic            [jbuf_pkg::FILL_W-1:0] fill_level_o
);
  import jbuf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  jbuf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .period_start_i(period_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  jbuf_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_in_i   (sample_in_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_out_o  (sample_out_o),
    .from_store_o  (from_store_o),
    .is_buffering_o(is_buffering_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

`default_nettype wire

@@ rtl/jbuf_ctrl.sv @@
// Controller: playback mode state machine, input handshake and output beat valid.
`default_nettype none

module jbuf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic                 period_start_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire jbuf_pkg::dp_status_t status_i,
  output jbuf_pkg::ctrl_cmd_t       cmd_o
);
  import jbuf_pkg::*;

  mode_e mode_q, mode_d;
  logic  out_valid_q, out_valid_d;
  logic  accept;
  logic  is_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BUFFERING;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    in_ready_o  = !out_valid_q || out_ready_i;
    accept      = in_valid_i && in_ready_o;
    is_read     = accept && req_type_i;
    mode_d      = mode_q;
    if (is_read && period_start_i) begin
      case (mode_q)
        MODE_BUFFERING: begin
          if (status_i.at_prefill) mode_d = MODE_PLAYING;
        end
        MODE_PLAYING: begin
          if (status_i.empty) mode_d = MODE_BUFFERING;
        end
        default: mode_d = MODE_BUFFERING;
      endcase
    end
    cmd_o.push      = accept && !req_type_i && !status_i.full;
    cmd_o.pop       = is_read && (mode_d == MODE_PLAYING) && !status_i.empty;
    cmd_o.load      = is_read;
    cmd_o.buffering = (mode_d == MODE_BUFFERING);
    out_valid_d     = is_read || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/jbuf_dp.sv @@
// Datapath: sample memory, pointers, fill count, threshold register and result registers.
`default_nettype none

module jbuf_dp #(
  parameter int unsigned STORE_DEPTH = 16384
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [jbuf_pkg::THR_W-1:0]      cfg_wdata_i,
  input  wire logic signed [jbuf_pkg::SMP_W-1:0]      sample_in_i,
  input  wire jbuf_pkg::ctrl_cmd_t                    cmd_i,
  output jbuf_pkg::dp_status_t                        status_o,
  output logic signed      [jbuf_pkg::SMP_W-1:0]      sample_out_o,
  output logic                                        from_store_o,
  output logic                                        is_buffering_o,
  output logic             [jbuf_pkg::FILL_W-1:0]     fill_level_o
);
  import jbuf_pkg::*;

  localparam int unsigned AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned CMPW = (CW > THR_W) ? CW : THR_W;

  logic [SMP_W-1:0] mem [STORE_DEPTH];

  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q, count_d;
  logic [THR_W-1:0] thr_q;
  logic [SMP_W-1:0] rdata_q;
  logic             from_store_q;
  logic             buffering_q;
  logic [CMPW-1:0]  count_ext, count_ext_q, thr_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= sample_in_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      thr_q    <= THR_RESET;
    end else begin
      if (cmd_i.push) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (cmd_i.pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
      count_q <= count_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      from_store_q <= cmd_i.pop;
      buffering_q  <= cmd_i.buffering;
      count_ext_q  <= CMPW'(count_d);
    end
  end

  assign count_ext           = CMPW'(count_q);
  assign thr_ext             = CMPW'(thr_q);
  assign status_o.empty      = (count_q == '0);
  assign status_o.full       = (count_ext == CMPW'(STORE_DEPTH));
  assign status_o.at_prefill = (count_ext >= thr_ext);

  assign sample_out_o   = from_store_q ? rdata_q : '0;
  assign from_store_o   = from_store_q;
  assign is_buffering_o = buffering_q;
  assign fill_level_o   = count_ext_q[FILL_W-1:0];

endmodule

`default_nettype wire
